@@ sv/ddo_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Differential drive odometry package
// Widths, constants, sequencer states and unit request/response types.
// ---------------------------------------------------------------------------
package ddo_pkg;

   localparam int TS_W          = 32;
   localparam int RATE_W        = 24;
   localparam int SEP_W         = 18;
   localparam int DIAM_W        = 17;
   localparam int PER_W         = 20;
   localparam int REQ_W         = 80;
   localparam int RSP_W         = 192;
   localparam int CSR_AW        = 4;
   localparam int CSR_DW        = 32;

   localparam int FRACTION_BITS = 16;
   localparam int CORDIC_STEPS  = 16;
   localparam int ATAN_ENTRIES  = 24;
   localparam int STEP_W        = 5;
   localparam int CORD_W        = 30;
   localparam int ANG_W         = 34;

   localparam int DIV_N         = 73;
   localparam int DIV_D         = 38;
   localparam int DIV_CW        = 7;
   localparam int MUL_W         = 73;
   localparam int MB_W          = 46;
   localparam int MN_W          = 6;
   localparam int ARC_W         = 37;
   localparam int SUM_W         = 38;
   localparam int MAG_W         = 37;
   localparam int QM_W          = 54;
   localparam int US_W          = 20;

   localparam logic [DIV_D-1:0]  ARC_DIV     = 38'd131072000000;
   localparam logic [DIV_N-1:0]  ARC_HALF    = 73'd65536000000;
   localparam logic [DIV_N-1:0]  ARC_LIMIT   = 73'd34359738367;
   localparam logic [CORD_W-1:0] CORDIC_GAIN = 30'd40752055;
   localparam logic [MB_W-1:0]   BAM_PER_RAD = 46'd44798133900177;
   localparam logic [US_W-1:0]   US_PER_S    = 20'd1000000;

   localparam logic [29:0] ATAN_BAM [0:ATAN_ENTRIES-1] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
      30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
   };

   typedef enum logic [1:0] {
      REG_SEPARATION = 2'd0,
      REG_DIAMETER   = 2'd1,
      REG_PERIOD     = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_P1, S_P2, S_ARC, S_SUM, S_MAG, S_Q1, S_B1, S_C1,
      S_DX, S_DY, S_Q2, S_B2, S_M1, S_SPD, S_M2, S_TRN, S_C2, S_EMIT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [DIV_N-1:0] dividend;
      logic [DIV_D-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_N-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic        start;
      logic [31:0] angle;
   } cord_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [CORD_W-1:0] cos_v;
      logic signed [CORD_W-1:0] sin_v;
   } cord_rsp_type;

endpackage
`default_nettype wire

@@ sv/diff_drive_wheel_odometry.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Differential drive wheel odometry
// Dead reckoning from wheel rates: arcs, midpoint heading, pose, rates, yaw.
// ---------------------------------------------------------------------------
//  Channel  | Ports      | Beat
//  ---------+------------+--------------------------------------------------
//  request  | req_*      | timestamp_us, left_rate, right_rate
//  response | rsp_*      | pose, heading, speed, turn rate, quaternion z/w
//  control  | csr_*      | separation @0x0, diameter @0x4, period @0x8
//
//  One item at a time. An accepted item's run is dominated by the bit-serial
//  divider: six quotients of 73 bits each (four when the elapsed time is
//  zero), plus shift-add products and two 16-step CORDIC runs. A dropped
//  item goes from the check step straight back to idle.
//  Synchronous reset clears the pose and the last update time and restores
//  the default config.
//  The response register holds its beat; the next item is accepted while it
//  waits, and that item stalls at its last step until the beat is taken.
// ---------------------------------------------------------------------------
module diff_drive_wheel_odometry (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // timestamp_us[31:0], left_rate[55:32], right_rate[79:56]
   input  logic [ddo_pkg::REQ_W-1:0]    req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // pose_x[31:0], pose_y[63:32], heading[95:64], linear_speed[126:96],
   // turn_rate[158:127], quat_z[174:159], quat_w[190:175], zero[191]
   output logic [ddo_pkg::RSP_W-1:0]    rsp_tdata,
   // rate_invalid[0]
   output logic                         rsp_tuser,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ddo_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [ddo_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [ddo_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);
   import ddo_pkg::*;

   state_type state_ff, state_in;
   logic      first_ff;

   logic [SEP_W-1:0]  sep_ff;
   logic [DIAM_W-1:0] diam_ff;
   logic [PER_W-1:0]  period_ff;

   logic [TS_W-1:0]          ts_ff;
   logic [TS_W-1:0]          dt_ff;
   logic [TS_W-1:0]          last_ff;
   logic signed [RATE_W-1:0] rate_l_ff;
   logic signed [RATE_W-1:0] rate_r_ff;
   logic                     wheel_ff;
   logic signed [ARC_W-1:0]  sl_ff;
   logic signed [ARC_W-1:0]  sr_ff;
   logic signed [SUM_W-1:0]  ssum_ff;
   logic signed [SUM_W-1:0]  sdiff_ff;
   logic [MAG_W-1:0]         smag_ff;
   logic [MAG_W-1:0]         dmag_ff;
   logic [DIV_N-1:0]         q_ff;
   logic [QM_W-1:0]          qmag_ff;
   logic [31:0]              mid_ff;
   logic [31:0]              acc_x_ff;
   logic [31:0]              acc_y_ff;
   logic [31:0]              acc_h_ff;
   logic [30:0]              speed_ff;
   logic [31:0]              turn_ff;

   logic                     rsp_valid_ff;
   logic [RSP_W-1:0]         rsp_data_ff;
   logic                     rsp_inv_ff;

   logic [MUL_W-1:0] mul_a_ff, mul_a_in;
   logic [MB_W-1:0]  mul_b_ff, mul_b_in;
   logic [MUL_W-1:0] mul_acc_ff;
   logic [MN_W-1:0]  mul_cnt_ff, mul_n_in;
   logic             mul_done_ff;
   logic             mul_start;

   div_req_type  div_req;
   div_rsp_type  div_rsp;
   cord_req_type cord_req;
   cord_rsp_type cord_rsp;

   logic signed [RATE_W-1:0] rate_sel;
   logic                     rate_neg;
   logic [RATE_W-1:0]        rate_mag;
   logic [ARC_W-2:0]         arc_mag;
   logic signed [ARC_W-1:0]  arc_val;
   logic [SEP_W-1:0]         sep_eff;
   logic [DIV_N-1:0]         quot_signed;
   logic signed [CORD_W-1:0] cord_sel;
   logic                     cord_neg;
   logic [CORD_W-1:0]        cord_mag;
   logic                     prod_neg;
   logic [MUL_W-1:0]         prod_s;
   logic [MUL_W-1:0]         prod_rnd;
   logic [31:0]              pos_inc;
   logic [63:0]              bam_sum;
   logic [31:0]              bam_inc;
   logic [30:0]              speed_sat;
   logic [31:0]              turn_mag;
   logic [31:0]              turn_val;
   logic [TS_W-1:0]          period_ext;
   logic [15:0]              quat_z;
   logic [15:0]              quat_w;

   function automatic logic [15:0] q14_clamp(input logic signed [CORD_W-1:0] v);
      logic signed [CORD_W:0] t;
      logic signed [CORD_W:0] r;
      begin
         t = (CORD_W+1)'(v) + (CORD_W+1)'(2048);
         r = t >>> 12;
         if (r > (CORD_W+1)'(16384)) begin
            r = (CORD_W+1)'(16384);
         end else if (r < -(CORD_W+1)'(16384)) begin
            r = -(CORD_W+1)'(16384);
         end
         return r[15:0];
      end
   endfunction

   ddo_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   ddo_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (cord_req),
      .rsp   (cord_rsp)
   );

   // datapath helpers
   always_comb begin
      period_ext  = TS_W'(period_ff);
      sep_eff     = (sep_ff == '0) ? SEP_W'(1) : sep_ff;
      rate_sel    = wheel_ff ? rate_r_ff : rate_l_ff;
      rate_neg    = rate_sel[RATE_W-1];
      rate_mag    = rate_neg ? RATE_W'(-rate_sel) : RATE_W'(rate_sel);
      arc_mag     = (div_rsp.quot > ARC_LIMIT) ? ARC_LIMIT[ARC_W-2:0]
                                                : div_rsp.quot[ARC_W-2:0];
      arc_val     = rate_neg ? -$signed({1'b0, arc_mag}) : $signed({1'b0, arc_mag});
      quot_signed = sdiff_ff[SUM_W-1] ? (DIV_N'(0) - div_rsp.quot) : div_rsp.quot;
      cord_sel    = (state_ff == S_DY) ? cord_rsp.sin_v : cord_rsp.cos_v;
      cord_neg    = cord_sel[CORD_W-1];
      cord_mag    = cord_neg ? CORD_W'(-cord_sel) : CORD_W'(cord_sel);
      prod_neg    = ssum_ff[SUM_W-1] ^ cord_neg;
      prod_s      = prod_neg ? (MUL_W'(0) - mul_acc_ff) : mul_acc_ff;
      prod_rnd    = prod_s + (MUL_W'(1) << 26);
      pos_inc     = prod_rnd[58:27];
      bam_sum     = mul_acc_ff[63:0] + 64'h0000_0000_8000_0000;
      bam_inc     = bam_sum[63:32];
      speed_sat   = (div_rsp.quot > DIV_N'(31'h7FFF_FFFF)) ? 31'h7FFF_FFFF
                                                          : div_rsp.quot[30:0];
      if (sdiff_ff[SUM_W-1]) begin
         turn_mag = (div_rsp.quot > DIV_N'(32'h8000_0000)) ? 32'h8000_0000
                                                          : div_rsp.quot[31:0];
         turn_val = 32'd0 - turn_mag;
      end else begin
         turn_mag = (div_rsp.quot > DIV_N'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                          : div_rsp.quot[31:0];
         turn_val = turn_mag;
      end
      quat_z      = q14_clamp(cord_rsp.sin_v);
      quat_w      = q14_clamp(cord_rsp.cos_v);
   end

   // sequencer: next state and unit launches
   always_comb begin
      state_in          = state_ff;
      mul_start         = 1'b0;
      mul_a_in          = '0;
      mul_b_in          = '0;
      mul_n_in          = '0;
      div_req.start     = 1'b0;
      div_req.dividend  = '0;
      div_req.divisor   = '0;
      cord_req.start    = 1'b0;
      cord_req.angle    = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = (dt_ff < period_ext) ? S_IDLE : S_P1;
         end
         S_P1: begin
            mul_start = first_ff;
            mul_a_in  = MUL_W'(rate_mag);
            mul_b_in  = MB_W'(diam_ff);
            mul_n_in  = MN_W'(DIAM_W);
            if (mul_done_ff) state_in = S_P2;
         end
         S_P2: begin
            mul_start = first_ff;
            mul_a_in  = mul_acc_ff;
            mul_b_in  = MB_W'(dt_ff);
            mul_n_in  = MN_W'(TS_W);
            if (mul_done_ff) state_in = S_ARC;
         end
         S_ARC: begin
            div_req.start    = first_ff;
            div_req.dividend = mul_acc_ff + ARC_HALF;
            div_req.divisor  = ARC_DIV;
            if (div_rsp.done) state_in = wheel_ff ? S_SUM : S_P1;
         end
         S_SUM: state_in = S_MAG;
         S_MAG: state_in = S_Q1;
         S_Q1: begin
            div_req.start    = first_ff;
            div_req.dividend = DIV_N'({dmag_ff, {FRACTION_BITS{1'b0}}}) + DIV_N'(sep_eff);
            div_req.divisor  = DIV_D'({sep_eff, 1'b0});
            if (div_rsp.done) state_in = S_B1;
         end
         S_B1: begin
            mul_start = first_ff;
            mul_a_in  = q_ff;
            mul_b_in  = BAM_PER_RAD;
            mul_n_in  = MN_W'(MB_W);
            if (mul_done_ff) state_in = S_C1;
         end
         S_C1: begin
            cord_req.start = first_ff;
            cord_req.angle = mid_ff;
            if (cord_rsp.done) state_in = S_DX;
         end
         S_DX, S_DY: begin
            mul_start = first_ff;
            mul_a_in  = MUL_W'(smag_ff);
            mul_b_in  = MB_W'(cord_mag);
            mul_n_in  = MN_W'(CORD_W);
            if (mul_done_ff) state_in = (state_ff == S_DX) ? S_DY : S_Q2;
         end
         S_Q2: begin
            div_req.start    = first_ff;
            div_req.dividend = DIV_N'({dmag_ff, {FRACTION_BITS{1'b0}}})
                               + DIV_N'(sep_eff >> 1);
            div_req.divisor  = DIV_D'(sep_eff);
            if (div_rsp.done) state_in = S_B2;
         end
         S_B2: begin
            mul_start = first_ff;
            mul_a_in  = q_ff;
            mul_b_in  = BAM_PER_RAD;
            mul_n_in  = MN_W'(MB_W);
            if (mul_done_ff) state_in = (dt_ff == '0) ? S_C2 : S_M1;
         end
         S_M1: begin
            mul_start = first_ff;
            mul_a_in  = MUL_W'(smag_ff);
            mul_b_in  = MB_W'(US_PER_S);
            mul_n_in  = MN_W'(US_W);
            if (mul_done_ff) state_in = S_SPD;
         end
         S_SPD: begin
            div_req.start    = first_ff;
            div_req.dividend = mul_acc_ff + DIV_N'(dt_ff);
            div_req.divisor  = DIV_D'({dt_ff, 1'b0});
            if (div_rsp.done) state_in = S_M2;
         end
         S_M2: begin
            mul_start = first_ff;
            mul_a_in  = MUL_W'(qmag_ff);
            mul_b_in  = MB_W'(US_PER_S);
            mul_n_in  = MN_W'(US_W);
            if (mul_done_ff) state_in = S_TRN;
         end
         S_TRN: begin
            div_req.start    = first_ff;
            div_req.dividend = mul_acc_ff + DIV_N'(dt_ff >> 1);
            div_req.divisor  = DIV_D'(dt_ff);
            if (div_rsp.done) state_in = S_C2;
         end
         S_C2: begin
            cord_req.start = first_ff;
            cord_req.angle = {1'b0, acc_h_ff[31:1]};
            if (cord_rsp.done) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= (state_in != state_ff);
      end
   end

   // shift-add multiplier, one multiplier bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_cnt_ff  <= '0;
         mul_done_ff <= 1'b0;
      end else begin
         mul_done_ff <= (mul_cnt_ff == MN_W'(1));
         if (mul_start) begin
            mul_a_ff   <= mul_a_in;
            mul_b_ff   <= mul_b_in;
            mul_acc_ff <= '0;
            mul_cnt_ff <= mul_n_in;
         end else if (mul_cnt_ff != '0) begin
            mul_acc_ff <= mul_acc_ff + (mul_b_ff[0] ? mul_a_ff : MUL_W'(0));
            mul_a_ff   <= mul_a_ff << 1;
            mul_b_ff   <= mul_b_ff >> 1;
            mul_cnt_ff <= mul_cnt_ff - MN_W'(1);
         end
      end
   end

   // pose state and result capture
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= '0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         acc_h_ff     <= '0;
         wheel_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_EMIT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  ts_ff     <= req_tdata[31:0];
                  rate_l_ff <= $signed(req_tdata[55:32]);
                  rate_r_ff <= $signed(req_tdata[79:56]);
                  dt_ff     <= req_tdata[31:0] - last_ff;
               end
            end
            S_CHECK: begin
               if (dt_ff >= period_ext) begin
                  last_ff  <= ts_ff;
                  wheel_ff <= 1'b0;
               end
            end
            S_ARC: begin
               if (div_rsp.done) begin
                  if (wheel_ff) sr_ff <= arc_val;
                  else          sl_ff <= arc_val;
                  wheel_ff <= 1'b1;
               end
            end
            S_SUM: begin
               ssum_ff  <= SUM_W'(sl_ff) + SUM_W'(sr_ff);
               sdiff_ff <= SUM_W'(sr_ff) - SUM_W'(sl_ff);
            end
            S_MAG: begin
               smag_ff <= ssum_ff[SUM_W-1] ? MAG_W'(-ssum_ff) : MAG_W'(ssum_ff);
               dmag_ff <= sdiff_ff[SUM_W-1] ? MAG_W'(-sdiff_ff) : MAG_W'(sdiff_ff);
            end
            S_Q1: begin
               if (div_rsp.done) q_ff <= quot_signed;
            end
            S_B1: begin
               if (mul_done_ff) mid_ff <= acc_h_ff + bam_inc;
            end
            S_DX: begin
               if (mul_done_ff) acc_x_ff <= acc_x_ff + pos_inc;
            end
            S_DY: begin
               if (mul_done_ff) acc_y_ff <= acc_y_ff + pos_inc;
            end
            S_Q2: begin
               if (div_rsp.done) begin
                  q_ff    <= quot_signed;
                  qmag_ff <= div_rsp.quot[QM_W-1:0];
               end
            end
            S_B2: begin
               if (mul_done_ff) begin
                  acc_h_ff <= acc_h_ff + bam_inc;
                  speed_ff <= '0;
                  turn_ff  <= '0;
               end
            end
            S_SPD: begin
               if (div_rsp.done) speed_ff <= speed_sat;
            end
            S_TRN: begin
               if (div_rsp.done) turn_ff <= turn_val;
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {1'b0, quat_w, quat_z, turn_ff, speed_ff,
                                   acc_h_ff, acc_y_ff, acc_x_ff};
                  rsp_inv_ff   <= (dt_ff == '0);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff    <= SEP_W'(22938);
         diam_ff   <= DIAM_W'(22938);
         period_ff <= PER_W'(10000);
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_index_type'(csr_paddr[3:2]))
            REG_SEPARATION: sep_ff    <= csr_pwdata[SEP_W-1:0];
            REG_DIAMETER:   diam_ff   <= csr_pwdata[DIAM_W-1:0];
            REG_PERIOD:     period_ff <= csr_pwdata[PER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index_type'(csr_paddr[3:2]))
         REG_SEPARATION: csr_prdata = CSR_DW'(sep_ff);
         REG_DIAMETER:   csr_prdata = CSR_DW'(diam_ff);
         REG_PERIOD:     csr_prdata = CSR_DW'(period_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_inv_ff;

   a_mul_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> (mul_cnt_ff == '0))
      else $error("multiplier launched while busy");

   a_drop_keeps_time: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && dt_ff < period_ext) |=>
         (state_ff == S_IDLE && $stable(last_ff)))
      else $error("dropped item disturbed the update time");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("response raised outside the emit step");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && !rsp_valid_ff) |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("emit step failed to load the response");

endmodule
`default_nettype wire

@@ sv/ddo_div.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Bit-serial divider
// Restoring division, one quotient bit per cycle, MSB of dividend first.
// ---------------------------------------------------------------------------
module ddo_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ddo_pkg::div_req_type req,
   output ddo_pkg::div_rsp_type rsp
);
   import ddo_pkg::*;

   logic [DIV_D-1:0]  rem_ff;
   logic [DIV_N-1:0]  sh_ff;
   logic [DIV_D-1:0]  dvs_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic              done_ff;
   logic [DIV_D:0]    shifted;
   logic [DIV_D:0]    trial;
   logic              ge;

   always_comb begin
      shifted = {rem_ff, sh_ff[DIV_N-1]};
      trial   = shifted - {1'b0, dvs_ff};
      ge      = !trial[DIV_D];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == DIV_CW'(1));
         if (req.start) begin
            rem_ff <= '0;
            sh_ff  <= req.dividend;
            dvs_ff <= req.divisor;
            cnt_ff <= DIV_CW'(DIV_N);
         end else if (cnt_ff != '0) begin
            rem_ff <= ge ? trial[DIV_D-1:0] : shifted[DIV_D-1:0];
            sh_ff  <= {sh_ff[DIV_N-2:0], ge};
            cnt_ff <= cnt_ff - DIV_CW'(1);
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = sh_ff;

endmodule
`default_nettype wire

@@ sv/ddo_cordic.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Iterative CORDIC rotator
// Cosine and sine of a binary angle, one micro-rotation per cycle.
// ---------------------------------------------------------------------------
module ddo_cordic (
   input  logic                  clock,
   input  logic                  reset,
   input  ddo_pkg::cord_req_type req,
   output ddo_pkg::cord_rsp_type rsp
);
   import ddo_pkg::*;

   logic signed [CORD_W-1:0] x_ff;
   logic signed [CORD_W-1:0] y_ff;
   logic signed [ANG_W-1:0]  z_ff;
   logic                     flip_ff;
   logic [STEP_W-1:0]        step_ff;
   logic                     busy_ff;
   logic                     done_ff;
   logic [31:0]              ang_off;
   logic                     flip;
   logic [31:0]              ang_fold;
   logic signed [CORD_W-1:0] xs;
   logic signed [CORD_W-1:0] ys;
   logic signed [ANG_W-1:0]  atan_z;

   always_comb begin
      // fold the left half plane onto the right one
      ang_off  = req.angle - 32'h4000_0000;
      flip     = !ang_off[31];
      ang_fold = flip ? (req.angle ^ 32'h8000_0000) : req.angle;
      xs       = x_ff >>> step_ff;
      ys       = y_ff >>> step_ff;
      atan_z   = $signed(ANG_W'(ATAN_BAM[step_ff]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            x_ff    <= $signed(CORDIC_GAIN);
            y_ff    <= '0;
            z_ff    <= ANG_W'($signed(ang_fold));
            flip_ff <= flip;
            step_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (!z_ff[ANG_W-1]) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - atan_z;
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + atan_z;
            end
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            step_ff <= step_ff + STEP_W'(1);
         end
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.cos_v = flip_ff ? -x_ff : x_ff;
   assign rsp.sin_v = flip_ff ? -y_ff : y_ff;

endmodule
`default_nettype wire

@@ tb/sv/diff_drive_wheel_odometry_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Wheel odometry testbench
// Sends timestamped wheel-rate beats through several register settings.
// A scoreboard predicts the pose, rates and yaw quaternion of each update
// that passes the period filter, and checks every response beat in order.
// ---------------------------------------------------------------------------
module diff_drive_wheel_odometry_tb;
   import ddo_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_CYCLES = 3000;
   localparam int PHASE_UPDATES = 130;

   typedef struct {
      bit [31:0] pose_x;
      bit [31:0] pose_y;
      bit [31:0] heading;
      bit [30:0] speed;
      bit [31:0] turn;
      bit [15:0] quat_z;
      bit [15:0] quat_w;
      bit        rate_invalid;
   } pose_beat_type;

   class odometry_scoreboard;
      bit [17:0] separation = 18'd22938;
      bit [16:0] diameter = 17'd22938;
      bit [19:0] period = 20'd10000;
      bit [31:0] acc_x, acc_y, acc_heading, last_stamp;
      pose_beat_type expected_poses[$];
      int updates = 0;
      int errors = 0;

      function void write_reg(csr_index_type idx, bit [31:0] value);
         case (idx)
            REG_SEPARATION: separation = value[17:0];
            REG_DIAMETER:   diameter = value[16:0];
            REG_PERIOD:     period = value[19:0];
            default: ;
         endcase
      endfunction

      function longint round_shift(longint v, int s);
         return (v + (longint'(1) << (s - 1))) >>> s;
      endfunction

      function bit [63:0] mag(longint v);
         return v < 0 ? 64'd0 - 64'(v) : 64'(v);
      endfunction

      function longint div_near(longint n, bit [63:0] d);
         bit [63:0] q;
         q = (mag(n) + d / 2) / d;
         return n < 0 ? -longint'(q) : longint'(q);
      endfunction

      // m * t / d rounded, split on t so nothing overflows 64 bits
      function bit [63:0] scaled_ratio(bit [63:0] m, bit [31:0] t, bit [63:0] d);
         bit [63:0] a, rest;
         a = m * 64'(t[31:16]);
         rest = (a % d) * 64'd65536 + m * 64'(t[15:0]);
         return (a / d) * 64'd65536 + (rest + d / 2) / d;
      endfunction

      function bit [63:0] per_second(bit [63:0] m, bit [63:0] d, bit [63:0] lim);
         bit [63:0] q, v;
         q = m / d;
         if (q > lim) return lim;
         v = q * 64'd1000000 + ((m % d) * 64'd1000000 + d / 2) / d;
         return v > lim ? lim : v;
      endfunction

      function bit [31:0] rad_to_bam(longint q);
         bit [63:0] p;
         p = 64'(q) * 64'd44798133900177 + 64'h80000000;
         return p[63:32];
      endfunction

      function void rotate(bit [31:0] ang, output longint c, output longint s);
         longint atan_steps[16] = '{536870912, 316933406, 167458907, 85004756,
            42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
            333772, 166886, 83443, 41722, 20861};
         bit [31:0] shifted;
         bit flip;
         longint x, y, z, xs, ys;
         shifted = ang - 32'h40000000;
         flip = shifted < 32'h80000000;
         if (flip) ang = ang ^ 32'h80000000;
         z = longint'($signed(ang));
         x = 40752055;
         y = 0;
         for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x -= ys; y += xs; z -= atan_steps[i];
            end else begin
               x += ys; y -= xs; z += atan_steps[i];
            end
         end
         c = flip ? -x : x;
         s = flip ? -y : y;
      endfunction

      function longint wheel_arc(longint rate, bit [31:0] dt);
         longint p;
         bit [63:0] m;
         longint a;
         p = rate * longint'(diameter);
         m = scaled_ratio(mag(p), dt, 64'd131072000000);
         a = m > 64'd34359738367 ? 64'sd34359738367 : longint'(m);
         return p < 0 ? -a : a;
      endfunction

      function bit [15:0] q14(longint v26);
         longint v;
         v = round_shift(v26, 12);
         if (v > 16384) v = 16384;
         if (v < -16384) v = -16384;
         return v[15:0];
      endfunction

      // advance the pose for one accepted request beat
      function void note_input(bit [31:0] ts, bit signed [23:0] left,
                               bit signed [23:0] right);
         bit [31:0] dt, mid;
         bit [63:0] b, tmag;
         longint sl, sr, ssum, sdiff, c, s, dx, dy, dth;
         pose_beat_type e;
         dt = ts - last_stamp;
         if (dt < 32'(period)) return;
         last_stamp = ts;
         b = separation == 0 ? 64'd1 : 64'(separation);
         sl = wheel_arc(longint'(left), dt);
         sr = wheel_arc(longint'(right), dt);
         ssum = sl + sr;
         sdiff = sr - sl;
         mid = acc_heading + rad_to_bam(div_near(sdiff * 65536, 2 * b));
         rotate(mid, c, s);
         dx = round_shift(ssum * c, 27);
         dy = round_shift(ssum * s, 27);
         acc_x += dx[31:0];
         acc_y += dy[31:0];
         acc_heading += rad_to_bam(div_near(sdiff * 65536, b));
         e.speed = '0;
         e.turn = '0;
         if (dt != 0) begin
            dth = div_near(sdiff * 65536, b);
            e.speed = 31'(per_second(mag(ssum), 64'(dt) * 2, 64'h7FFFFFFF));
            tmag = per_second(mag(dth), 64'(dt), dth < 0 ? 64'h80000000 : 64'h7FFFFFFF);
            e.turn = dth < 0 ? 32'd0 - tmag[31:0] : tmag[31:0];
         end
         rotate(acc_heading >> 1, c, s);
         e.pose_x = acc_x;
         e.pose_y = acc_y;
         e.heading = acc_heading;
         e.quat_z = q14(s);
         e.quat_w = q14(c);
         e.rate_invalid = dt == 0;
         expected_poses.insert(expected_poses.size(), e);
         updates++;
      endfunction

      task report_mismatch(string what, bit [63:0] got, bit [63:0] want);
         $display("mismatch on %s: got %h, want %h", what, got, want);
         errors++;
      endtask

      task check_result(pose_beat_type r);
         pose_beat_type e;
         if (expected_poses.size() == 0) begin
            report_mismatch("unexpected beat", 64'(r.pose_x), 0);
            return;
         end
         e = expected_poses.pop_front();
         if (r.pose_x != e.pose_x) report_mismatch("pose_x", r.pose_x, e.pose_x);
         if (r.pose_y != e.pose_y) report_mismatch("pose_y", r.pose_y, e.pose_y);
         if (r.heading != e.heading) report_mismatch("heading", r.heading, e.heading);
         if (r.speed != e.speed) report_mismatch("linear_speed", r.speed, e.speed);
         if (r.turn != e.turn) report_mismatch("turn_rate", r.turn, e.turn);
         if (r.quat_z != e.quat_z) report_mismatch("quat_z", r.quat_z, e.quat_z);
         if (r.quat_w != e.quat_w) report_mismatch("quat_w", r.quat_w, e.quat_w);
         if (r.rate_invalid != e.rate_invalid)
            report_mismatch("rate_invalid", r.rate_invalid, e.rate_invalid);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   odometry_scoreboard pose_board = new();
   bit hold_request = 1'b0;
   int burst_left = 0;
   int idle_cycles = 0;

   diff_drive_wheel_odometry dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // receiver: the ready percentage is redrawn at intervals, plus one long hold-off
   initial begin
      int ready_pct;
      ready_pct = 100;
      forever begin
         for (int n = 0; n < 200; n++) begin
            @(posedge clock);
            if (hold_request) begin
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
               hold_request = 1'b0;
            end
            rsp_tready <= $urandom_range(0, 99) < ready_pct;
         end
         case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 70;
            2: ready_pct = 30;
            default: ready_pct = 5;
         endcase
      end
   end

   always @(posedge clock) begin
      pose_beat_type r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         r.pose_x = rsp_tdata[31:0];
         r.pose_y = rsp_tdata[63:32];
         r.heading = rsp_tdata[95:64];
         r.speed = rsp_tdata[126:96];
         r.turn = rsp_tdata[158:127];
         r.quat_z = rsp_tdata[174:159];
         r.quat_w = rsp_tdata[190:175];
         r.rate_invalid = rsp_tuser;
         pose_board.check_result(r);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task send_beat(bit [31:0] ts, bit signed [23:0] left, bit signed [23:0] right);
      int gap;
      bit ready_seen;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         case ($urandom_range(0, 5))
            0, 1: gap = 0;
            2: gap = $urandom_range(100, 1200);
            default: gap = $urandom_range(1, 40);
         endcase
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {right, left, ts};
      // take ready mid-cycle so the accepting edge itself is seen
      do begin
         @(negedge clock);
         ready_seen = req_tready;
         @(posedge clock);
      end while (!ready_seen);
      pose_board.note_input(ts, left, right);
   endtask

   task drain;
      req_tvalid <= 1'b0;
      while (pose_board.expected_poses.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task csr_write(csr_index_type idx, bit [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'(idx) << 2;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      pose_board.write_reg(idx, value);
   endtask

   task set_regs(bit [31:0] sep, bit [31:0] diam, bit [31:0] per);
      csr_write(REG_SEPARATION, sep);
      csr_write(REG_DIAMETER, diam);
      csr_write(REG_PERIOD, per);
   endtask

   function bit [23:0] pick_rate();
      case ($urandom_range(0, 7))
         0: return 24'($urandom);
         1: case ($urandom_range(0, 3))
               0: return 24'h800000;
               1: return 24'h7FFFFF;
               2: return 24'h000000;
               default: return 24'hFFFFFF;
            endcase
         default: return 24'($signed($urandom_range(0, 80 << 16)) - (40 << 16));
      endcase
   endfunction

   // offset from the last update: mostly due, some early, some huge or zero
   function bit [31:0] pick_delta();
      bit [31:0] p;
      int r;
      p = 32'(pose_board.period);
      r = $urandom_range(0, 99);
      if (r < 10) return p == 0 ? 32'd0 : 32'($urandom_range(0, p - 1));
      if (r < 20) return p;
      if (r < 30) return $urandom;
      if (r < 35) return 32'd0;
      return p + 32'($urandom_range(0, p / 4 + 50));
   endfunction

   task random_updates(int count);
      int target;
      target = pose_board.updates + count;
      while (pose_board.updates < target)
         send_beat(pose_board.last_stamp + pick_delta(), pick_rate(), pick_rate());
   endtask

   // random register value with junk above the field to exercise masking
   function bit [31:0] junk_reg(int width, bit [31:0] lo, bit [31:0] hi);
      return ($urandom << width) | $urandom_range(lo, hi);
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: too early, on time, then extreme rate pairs
      send_beat(32'd0, 24'h7FFFFF, 24'h800000);
      send_beat(32'd9999, 24'h7FFFFF, 24'h7FFFFF);
      send_beat(32'd10000, 24'h7FFFFF, 24'h7FFFFF);
      send_beat(32'd20000, 24'h800000, 24'h800000);
      send_beat(32'd30000, 24'h800000, 24'h7FFFFF);
      send_beat(32'd40000, 24'h7FFFFF, 24'h800000);
      send_beat(32'd50000, 24'h000000, 24'h000000);
      send_beat(32'd60000, 24'hFFFFFF, 24'h000001);
      send_beat(32'd60000 + 32'hFFFFFFFF, 24'h123456, 24'hEDCBA9);
      random_updates(PHASE_UPDATES);
      drain();

      // tiny track, largest wheel, no period: zero elapsed time and arc clamp
      set_regs(32'd1, 32'd131071, 32'd0);
      send_beat(pose_board.last_stamp, 24'h7FFFFF, 24'h800000);
      send_beat(pose_board.last_stamp + 32'hFFFFFFFF, 24'h7FFFFF, 24'h7FFFFF);
      send_beat(pose_board.last_stamp + 32'hFFFFFFFF, 24'h800000, 24'h7FFFFF);
      send_beat(pose_board.last_stamp, 24'h000010, 24'h000020);
      random_updates(PHASE_UPDATES);
      drain();

      // widest track, smallest wheel, a long period; hold the receiver off
      set_regs(32'd262143, 32'd1, 32'd1000000);
      hold_request = 1'b1;
      random_updates(PHASE_UPDATES);
      drain();

      // zero separation and an all-ones period written past the field
      set_regs(32'd0, junk_reg(17, 1, 131071), 32'hFFFFFFFF);
      random_updates(PHASE_UPDATES);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         set_regs(junk_reg(18, 1, 262143), junk_reg(17, 1, 131071),
                  junk_reg(20, 0, 20000));
         random_updates(PHASE_UPDATES);
         drain();
      end

      set_regs(32'd22938, 32'd22938, 32'd1000);
      random_updates(PHASE_UPDATES);
      drain();

      if (pose_board.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

@@ files.f @@
sv/ddo_pkg.sv
sv/ddo_div.sv
sv/ddo_cordic.sv
sv/diff_drive_wheel_odometry.sv
tb/sv/diff_drive_wheel_odometry_tb.sv
